// ===== hdl/limit_order_book_matcher_top_macros.svh =====
// Assertion macros for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`ifndef SYNTH
`define LOBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("order book assertion failed");
`define LOBM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("order book assertion failed");
`else
`define LOBM_ASSERT(lbl, prop)
`define LOBM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LVL_WT,
    S_Q_WT,
    S_REST_RD,
    S_REST_WT,
    S_DONE
  } state_t;

endpackage

// ===== hdl/limit_order_book_matcher_top.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority order book: match against the opposite side, rest the
// remainder at the order price, or drop it if that level's queue is full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one order per beat: kind, side,
//   price, quantity. Output channel (out_valid/out_ready) returns one result
//   beat per order: filled, rested, dropped.
//   One order is in work at a time. A rest-only order passes through S_REST_RD,
//   S_REST_WT and S_DONE, which loads the output register and raises out_valid;
//   the input reopens when S_DONE returns to S_IDLE. A match order makes one
//   level-table read for each of the L opposite-side price levels walked and
//   one quantity read for each of the F resting orders touched. A buy walks
//   up from level 0, a sell down from the top level, so L can reach
//   PRICE_LEVELS.
//   After reset the level tables are swept to empty, one entry a cycle, all
//   2*PRICE_LEVELS entries, with in_ready low.
//   The result sits in an output register; the next order is accepted while
//   it waits, but its own result stalls in the last step until the receiver
//   takes the pending beat.
// ----------------------------------------------------------------------------
`include "limit_order_book_matcher_top_macros.svh"

module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int PRICE_LEVELS = 256,
  parameter int QUEUE_DEPTH  = 8,
  parameter int QTY_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        side,
  input  logic [7:0]  price,
  input  logic [15:0] quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] filled,
  output logic [15:0] rested,
  output logic        dropped
);

  localparam int LW    = $clog2(PRICE_LEVELS);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QW    = QTY_BITS;
  localparam int SLOTS = PRICE_LEVELS * QUEUE_DEPTH;
  localparam int MD    = 2 * PRICE_LEVELS;
  localparam int QD2   = 2 * SLOTS;
  localparam int MAW   = $clog2(MD);
  localparam int QAW   = $clog2(QD2);
  localparam int MDW   = HW + CW;

  // level table: {head, count} per side and level; side 0 bids, side 1 asks
  logic [MDW-1:0] meta_mem [MD];
  logic [QW-1:0]  qty_mem  [QD2];

  logic           meta_we, meta_re;
  logic [MAW-1:0] meta_waddr, meta_raddr;
  logic [MDW-1:0] meta_wdata, meta_rdata;
  logic           qty_we, qty_re;
  logic [QAW-1:0] qty_waddr, qty_raddr;
  logic [QW-1:0]  qty_wdata, qty_rdata;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (qty_we) begin
      qty_mem[qty_waddr] <= qty_wdata;
    end
    if (qty_re) begin
      qty_rdata <= qty_mem[qty_raddr];
    end
  end

  function automatic logic [MAW-1:0] meta_addr(input logic s, input logic [LW-1:0] l);
    meta_addr = s ? (MAW'(PRICE_LEVELS) + MAW'(l)) : MAW'(l);
  endfunction

  function automatic logic [QAW-1:0] qty_addr(input logic s, input logic [LW-1:0] l,
                                              input logic [HW-1:0] idx);
    logic [QAW-1:0] base;
    base = s ? QAW'(SLOTS) : '0;
    qty_addr = base + QAW'(l) * QAW'(QUEUE_DEPTH) + QAW'(idx);
  endfunction

  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    head_inc = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + HW'(1);
  endfunction

  state_t         state, state_next;
  logic [MAW-1:0] clr_idx, clr_idx_next;
  logic           side_r, side_r_next;
  logic [LW-1:0]  price_r, price_r_next;
  logic [LW-1:0]  lvl, lvl_next;
  logic [QW-1:0]  rem, rem_next;
  logic [QW-1:0]  qty0, qty0_next;
  logic [HW-1:0]  cur_head, cur_head_next;
  logic [CW-1:0]  cur_cnt, cur_cnt_next;
  logic [QW-1:0]  rested_r, rested_r_next;
  logic           dropped_r, dropped_r_next;
  logic           out_load;

  logic [HW-1:0]  rd_head;
  logic [CW-1:0]  rd_cnt;
  assign rd_head = meta_rdata[MDW-1:CW];
  assign rd_cnt  = meta_rdata[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    side_r    <= side_r_next;
    price_r   <= price_r_next;
    lvl       <= lvl_next;
    rem       <= rem_next;
    qty0      <= qty0_next;
    cur_head  <= cur_head_next;
    cur_cnt   <= cur_cnt_next;
    rested_r  <= rested_r_next;
    dropped_r <= dropped_r_next;
  end

  always_comb begin
    logic [QW-1:0]  qin, front, nf, rem_n;
    logic [HW-1:0]  head_n;
    logic [CW-1:0]  cnt_n;
    logic [LW-1:0]  start_lvl, psat;
    logic [CW:0]    tail;
    logic           pop, adv;

    state_next     = state;
    clr_idx_next   = clr_idx;
    side_r_next    = side_r;
    price_r_next   = price_r;
    lvl_next       = lvl;
    rem_next       = rem;
    qty0_next      = qty0;
    cur_head_next  = cur_head;
    cur_cnt_next   = cur_cnt;
    rested_r_next  = rested_r;
    dropped_r_next = dropped_r;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    meta_we        = 1'b0;
    meta_waddr     = '0;
    meta_wdata     = '0;
    meta_re        = 1'b0;
    meta_raddr     = '0;
    qty_we         = 1'b0;
    qty_waddr      = '0;
    qty_wdata      = '0;
    qty_re         = 1'b0;
    qty_raddr      = '0;
    qin            = QW'(quantity);
    front          = qty_rdata;
    nf             = '0;
    rem_n          = rem;
    head_n         = cur_head;
    cnt_n          = cur_cnt;
    start_lvl      = side ? LW'(PRICE_LEVELS - 1) : '0;
    psat           = (32'(price) >= PRICE_LEVELS) ? LW'(PRICE_LEVELS - 1) : LW'(price);
    tail           = '0;
    pop            = 1'b0;
    adv            = 1'b0;

    case (state)
      S_CLEAR: begin
        meta_we      = 1'b1;
        meta_waddr   = clr_idx;
        clr_idx_next = clr_idx + MAW'(1);
        if (clr_idx == MAW'(MD - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          side_r_next    = side;
          price_r_next   = psat;
          rem_next       = qin;
          qty0_next      = qin;
          lvl_next       = start_lvl;
          rested_r_next  = '0;
          dropped_r_next = 1'b0;
          if (kind && qin != '0) begin
            meta_re    = 1'b1;
            meta_raddr = meta_addr(~side, start_lvl);
            state_next = S_LVL_WT;
          end else begin
            state_next = S_REST_RD;
          end
        end
      end
      S_LVL_WT: begin
        cur_head_next = rd_head;
        cur_cnt_next  = rd_cnt;
        if (rd_cnt == '0) begin
          adv = 1'b1;
        end else begin
          qty_re     = 1'b1;
          qty_raddr  = qty_addr(~side_r, lvl, rd_head);
          state_next = S_Q_WT;
        end
      end
      S_Q_WT: begin
        if (front >= rem) begin
          nf    = front - rem;
          rem_n = '0;
          pop   = (nf == '0);
          if (!pop) begin
            qty_we    = 1'b1;
            qty_waddr = qty_addr(~side_r, lvl, cur_head);
            qty_wdata = nf;
          end
        end else begin
          rem_n = rem - front;
          pop   = 1'b1;
        end
        if (pop) begin
          head_n = head_inc(cur_head);
          cnt_n  = cur_cnt - CW'(1);
        end
        rem_next      = rem_n;
        cur_head_next = head_n;
        cur_cnt_next  = cnt_n;
        if (rem_n != '0 && cnt_n != '0) begin
          qty_re    = 1'b1;
          qty_raddr = qty_addr(~side_r, lvl, head_n);
        end else begin
          meta_we    = 1'b1;
          meta_waddr = meta_addr(~side_r, lvl);
          meta_wdata = {head_n, cnt_n};
          adv        = 1'b1;
        end
      end
      S_REST_RD: begin
        meta_re    = 1'b1;
        meta_raddr = meta_addr(side_r, price_r);
        state_next = S_REST_WT;
      end
      S_REST_WT: begin
        if (rem != '0) begin
          if (rd_cnt >= CW'(QUEUE_DEPTH)) begin
            dropped_r_next = 1'b1;
          end else begin
            tail = (CW + 1)'(rd_head) + (CW + 1)'(rd_cnt);
            if (tail >= (CW + 1)'(QUEUE_DEPTH)) begin
              tail = tail - (CW + 1)'(QUEUE_DEPTH);
            end
            qty_we        = 1'b1;
            qty_waddr     = qty_addr(side_r, price_r, HW'(tail));
            qty_wdata     = rem;
            meta_we       = 1'b1;
            meta_waddr    = meta_addr(side_r, price_r);
            meta_wdata    = {rd_head, rd_cnt + CW'(1)};
            rested_r_next = rem;
          end
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // step to the next opposite-side level, or finish matching
    if (adv) begin
      if (rem_n == '0 || lvl == price_r) begin
        state_next = S_REST_RD;
      end else begin
        lvl_next   = side_r ? lvl - LW'(1) : lvl + LW'(1);
        meta_re    = 1'b1;
        meta_raddr = meta_addr(~side_r, lvl_next);
        state_next = S_LVL_WT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filled  <= 16'(qty0 - rem);
      rested  <= 16'(rested_r);
      dropped <= dropped_r;
    end
  end

  `LOBM_ASSERT(a_cnt_bound, (state == S_LVL_WT || state == S_REST_WT) |-> (rd_cnt <= CW'(QUEUE_DEPTH)))
  `LOBM_ASSERT_NEXT(a_rem_falls, state == S_Q_WT, rem <= $past(rem))
  `LOBM_ASSERT(a_meta_no_clash, (meta_we && meta_re) |-> (meta_waddr != meta_raddr))

endmodule

// ===== sim/limit_order_book_matcher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top_tb
// Drives orders into the matcher and checks each result against an in-bench
// price-time priority book: directed corner orders, then random order flow
// under several idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top_tb;
  import lobm_pkg::*;

  localparam int LEVELS = 256;
  localparam int DEPTH  = 8;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] filled;
    logic [15:0] rested;
    logic        dropped;
  } fill_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic        side = 1'b0;
  logic [7:0]  price = '0;
  logic [15:0] quantity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] filled;
  logic [15:0] rested;
  logic        dropped;

  // book copy
  logic [15:0] ask_qty [LEVELS*DEPTH];
  logic [15:0] bid_qty [LEVELS*DEPTH];
  int          ask_head [LEVELS];
  int          bid_head [LEVELS];
  int          ask_cnt [LEVELS];
  int          bid_cnt [LEVELS];

  fill_report_t pending_reports [$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  idle_cycles = 0;

  limit_order_book_matcher_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic take_from_level(bit from_ask, int lvl, inout int remain);
    int slot;
    while (remain > 0 && (from_ask ? ask_cnt[lvl] : bid_cnt[lvl]) > 0) begin
      slot = lvl * DEPTH + (from_ask ? ask_head[lvl] : bid_head[lvl]);
      if ((from_ask ? ask_qty[slot] : bid_qty[slot]) > remain) begin
        if (from_ask) ask_qty[slot] -= remain[15:0];
        else bid_qty[slot] -= remain[15:0];
        remain = 0;
      end else begin
        remain -= from_ask ? ask_qty[slot] : bid_qty[slot];
        if (from_ask) begin
          ask_head[lvl] = (ask_head[lvl] + 1) % DEPTH;
          ask_cnt[lvl]--;
        end else begin
          bid_head[lvl] = (bid_head[lvl] + 1) % DEPTH;
          bid_cnt[lvl]--;
        end
      end
    end
  endtask

  task automatic predict_fill(bit k, bit s, int p, int q);
    int remain;
    int lvl;
    fill_report_t r;
    remain = q;
    r = '0;
    if (k) begin
      if (!s) begin
        for (lvl = 0; lvl <= p && remain > 0; lvl++) take_from_level(1'b1, lvl, remain);
      end else begin
        for (lvl = LEVELS - 1; lvl >= p && remain > 0; lvl--)
          take_from_level(1'b0, lvl, remain);
      end
    end
    if (remain > 0) begin
      if (!s && bid_cnt[p] < DEPTH) begin
        bid_qty[p*DEPTH + (bid_head[p] + bid_cnt[p]) % DEPTH] = remain[15:0];
        bid_cnt[p]++;
        r.rested = remain[15:0];
      end else if (s && ask_cnt[p] < DEPTH) begin
        ask_qty[p*DEPTH + (ask_head[p] + ask_cnt[p]) % DEPTH] = remain[15:0];
        ask_cnt[p]++;
        r.rested = remain[15:0];
      end else begin
        r.dropped = 1'b1;
      end
    end
    r.filled = 16'(q - remain);
    pending_reports.push_back(r);
  endtask

  // valid drops at the negedge after a beat; the next beat starts a later negedge
  task automatic send_order(bit k, bit s, int p, int q);
    do begin
      @(negedge clk);
    end while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    kind <= k;
    side <= s;
    price <= 8'(p);
    quantity <= 16'(q);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_fill(k, s, p, q);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  always @(negedge clk)
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    fill_report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (filled !== exp_r.filled) begin
          $error("filled: expected %0d, got %0d", exp_r.filled, filled);
          error_count++;
        end
        if (rested !== exp_r.rested) begin
          $error("rested: expected %0d, got %0d", exp_r.rested, rested);
          error_count++;
        end
        if (dropped !== exp_r.dropped) begin
          $error("dropped: expected %0d, got %0d", exp_r.dropped, dropped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("limit_order_book_matcher_top_tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    int i;
    send_order(1'b0, 1'b0, 0, 0);        // zero quantity: no effect
    send_order(1'b1, 1'b0, 255, 0);
    send_order(1'b1, 1'b0, 255, 100);    // buy with empty asks rests
    send_order(1'b1, 1'b1, 0, 40);       // sell hits top bid, partial
    send_order(1'b1, 1'b1, 255, 60);     // exact exhaustion
    send_order(1'b0, 1'b1, 10, 65535);
    send_order(1'b0, 1'b1, 12, 5);
    send_order(1'b1, 1'b0, 12, 65535);   // exactly exhausts the level-10 ask, nothing rests
    // fill one level queue then overflow
    for (i = 0; i < DEPTH + 1; i++) send_order(1'b0, 1'b1, 200, 1 + i);
    send_order(1'b1, 1'b1, 200, 3);      // crosses own level? no: sells vs bids
    send_order(1'b1, 1'b0, 199, 7);      // buy below the 200 asks fills 5 at level 12, rests 2
    send_order(1'b1, 1'b0, 200, 4);      // takes oldest first
    send_order(1'b1, 1'b0, 200, 65535);  // clears the level
  endtask

  task automatic test_random(int count);
    int i;
    int p;
    int q;
    for (i = 0; i < count; i++) begin
      p = ($urandom_range(3) == 0) ? $urandom_range(255) : 100 + $urandom_range(15);
      case ($urandom_range(3))
        0: q = $urandom_range(65535);
        1: q = 0;
        default: q = $urandom_range(300);
      endcase
      send_order(1'($urandom_range(1)), 1'($urandom_range(1)), p, q);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      test_random(30);
    join
  endtask

  initial begin
    for (int i = 0; i < LEVELS; i++) begin
      ask_head[i] = 0; bid_head[i] = 0; ask_cnt[i] = 0; bid_cnt[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 15; recv_idle_pct = 88;
    test_random(300);
    send_idle_pct = 88; recv_idle_pct = 15;
    test_random(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(350);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("limit_order_book_matcher_top_tb: done, clean");
    else $display("limit_order_book_matcher_top_tb: done, errors");
    $finish;
  end

endmodule
